/* sv/grid_dark_marker_locator_top_assert.svh */
// Assertion macros shared by the grid dark marker locator RTL.
`ifndef GRID_DARK_MARKER_LOCATOR_TOP_ASSERT_SVH
`define GRID_DARK_MARKER_LOCATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDML_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdml check failed");

// Consequent must hold in the cycle after the antecedent.
`define GDML_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdml check failed");

`endif

/* sv/gdml_pkg.sv */
// Types and constants of the grid dark marker locator.
package gdml_pkg;

    // Grid geometry and field widths.
    localparam int CELLS     = 6;
    localparam int GRID_ROWS = 3;
    localparam int CELL_W    = 3;
    localparam int X_W       = 10;
    localparam int Y_W       = 9;
    localparam int PIX_W     = 8;
    localparam int POS_W     = 13;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_LEFT    = 3'd0,
        CFG_WINDOW_TOP     = 3'd1,
        CFG_CELL_WIDTH     = 3'd2,
        CFG_CELL_HEIGHT    = 3'd3,
        CFG_DARK_THRESHOLD = 3'd4,
        CFG_BRIGHT_VALUE   = 3'd5
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [9:0] RST_WINDOW_LEFT    = 10'd200;
    localparam logic [8:0] RST_WINDOW_TOP     = 9'd320;
    localparam logic [8:0] RST_CELL_WIDTH     = 9'd100;
    localparam logic [7:0] RST_CELL_HEIGHT    = 8'd50;
    localparam logic [7:0] RST_DARK_THRESHOLD = 8'd210;
    localparam logic [7:0] RST_BRIGHT_VALUE   = 8'd255;

    // Binarized level that counts as a hit.
    localparam logic [PIX_W-1:0] HIT_LEVEL = 8'd200;

    // BT.601 gray weights in 14-bit fixed point.
    localparam int PROD_W     = 22;
    localparam int SUM_W      = 23;
    localparam int GRAY_SHIFT = 14;
    localparam logic [PROD_W-1:0] W_BLUE  = 22'd1868;
    localparam logic [PROD_W-1:0] W_GREEN = 22'd9617;
    localparam logic [PROD_W-1:0] W_RED   = 22'd4899;
    localparam logic [SUM_W-1:0]  GRAY_ROUND = 23'd8192;

    // Register set.
    typedef struct packed {
        logic [9:0] window_left;
        logic [8:0] window_top;
        logic [8:0] cell_width;
        logic [7:0] cell_height;
        logic [7:0] dark_threshold;
        logic [7:0] bright_value;
    } cfg_t;

    // One classified pixel leaving the front end.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              hit;
        logic [CELL_W-1:0] cell_id;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
    } pix_event_t;

endpackage

/* sv/gdml_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module gdml_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/gdml_front.sv */
// Pixel front end: frame position, window and cell lookup, gray conversion and hit test.
module gdml_front #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [gdml_pkg::PIX_W-1:0]    blue,
    input  logic [gdml_pkg::PIX_W-1:0]    green,
    input  logic [gdml_pkg::PIX_W-1:0]    red,
    input  logic                          frame_end,
    input  gdml_pkg::cfg_t                cfg,
    output gdml_pkg::pix_event_t          ev
);
    import gdml_pkg::*;

    localparam int CW = $clog2(FRAME_WIDTH);
    localparam int RW = $clog2(FRAME_HEIGHT);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [POS_W-1:0] col_x, row_x, rx, ry;
    logic [POS_W-1:0] cw_x, cw2_x, ch_x, ch2_x, ch3_x;
    logic             in_window;
    logic [CELL_W-1:0] cell_row, cell_sel;

    logic              s1_valid_reg;
    logic              s1_last_reg;
    logic              s1_inside_reg;
    logic [CELL_W-1:0] s1_cell_reg;
    logic [X_W-1:0]    s1_x_reg;
    logic [Y_W-1:0]    s1_y_reg;
    logic [PROD_W-1:0] s1_pb_reg, s1_pg_reg, s1_pr_reg;

    logic [SUM_W-1:0] gray_sum;
    logic [PIX_W-1:0] gray;

    // Raster position of the next pixel, wrapping at the frame size; frame_end restarts it.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_reg == CW'(FRAME_WIDTH - 1))
            begin
                col_next = '0;
                row_next = (row_reg == RW'(FRAME_HEIGHT - 1)) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Window membership and cell number of the current pixel.
    always_comb
    begin
        col_x = POS_W'(col_reg);
        row_x = POS_W'(row_reg);
        rx    = col_x - POS_W'(cfg.window_left);
        ry    = row_x - POS_W'(cfg.window_top);
        cw_x  = POS_W'(cfg.cell_width);
        cw2_x = POS_W'({cfg.cell_width, 1'b0});
        ch_x  = POS_W'(cfg.cell_height);
        ch2_x = POS_W'({cfg.cell_height, 1'b0});
        ch3_x = ch2_x + ch_x;

        in_window = (col_x >= POS_W'(cfg.window_left)) && (row_x >= POS_W'(cfg.window_top))
                 && (cfg.cell_width != '0) && (cfg.cell_height != '0)
                 && (rx < cw2_x) && (ry < ch3_x);

        priority if (ry >= ch2_x)
        begin
            cell_row = CELL_W'(2);
        end
        else if (ry >= ch_x)
        begin
            cell_row = CELL_W'(1);
        end
        else
        begin
            cell_row = '0;
        end

        cell_sel = (rx >= cw_x) ? CELL_W'(GRID_ROWS) + cell_row : cell_row;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
        end
    end

    // Stage one payload: position results and the weighted channel products.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg   <= frame_end;
            s1_inside_reg <= in_window;
            s1_cell_reg   <= cell_sel;
            s1_x_reg      <= rx[X_W-1:0];
            s1_y_reg      <= ry[Y_W-1:0];
            s1_pb_reg     <= PROD_W'(blue) * W_BLUE;
            s1_pg_reg     <= PROD_W'(green) * W_GREEN;
            s1_pr_reg     <= PROD_W'(red) * W_RED;
        end
    end

    // Gray value and inverse binarization against the hit level.
    always_comb
    begin
        gray_sum = SUM_W'(s1_pb_reg) + SUM_W'(s1_pg_reg) + SUM_W'(s1_pr_reg) + GRAY_ROUND;
        gray     = gray_sum[GRAY_SHIFT +: PIX_W];

        ev.valid   = s1_valid_reg;
        ev.last    = s1_last_reg;
        ev.hit     = s1_inside_reg && (gray <= cfg.dark_threshold)
                  && (cfg.bright_value >= HIT_LEVEL);
        ev.cell_id = s1_cell_reg;
        ev.x       = s1_x_reg;
        ev.y       = s1_y_reg;
    end

endmodule

/* sv/grid_dark_marker_locator_top.sv */
// A frame_end pixel, once registered in the front end, starts the readout of six back-to-back points.
// Throughput: one pixel per cycle unless frame_end waits; RAM points read one per cycle on out_ready.
// A frame_end pixel waits while the previous frame's points are still being read out of the RAM.
// The point RAM has two banks, one being filled while the other is read out.
// Reset: asynchronous, active low; clears position, found flags and handshake state, no clearing pass.
`include "grid_dark_marker_locator_top_assert.svh"

module grid_dark_marker_locator_top #(
    parameter int FRAME_WIDTH  = 640,
    parameter int FRAME_HEIGHT = 480
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Pixel input channel.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [gdml_pkg::PIX_W-1:0]         blue,
    input  logic [gdml_pkg::PIX_W-1:0]         green,
    input  logic [gdml_pkg::PIX_W-1:0]         red,
    input  logic                               frame_end,
    // Point output channel.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gdml_pkg::CELL_W-1:0]        cell_index,
    output logic [gdml_pkg::X_W-1:0]           point_x,
    output logic [gdml_pkg::Y_W-1:0]           point_y,
    output logic                               found,
    output logic                               last_point,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [gdml_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gdml_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import gdml_pkg::*;

    localparam int RAM_W     = X_W + Y_W;
    localparam int RAM_DEPTH = 2 * (1 << CELL_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    cfg_t       cfg_reg, cfg_next;
    pix_event_t ev;
    logic       in_xfer;

    logic                          wr_bank_reg, wr_bank_next;
    logic [1:0][CELLS-1:0]         found_reg, found_next;
    logic                          rd_busy_reg, rd_busy_next;
    logic                          rd_bank_reg, rd_bank_next;
    logic [CELL_W-1:0]             rd_idx_reg, rd_idx_next;
    logic                          out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]             out_index_reg, out_index_next;
    logic                          out_found_reg, out_found_next;
    logic                          out_last_reg, out_last_next;

    logic                          ram_we, ram_re, advance;
    logic [RAM_AW-1:0]             ram_waddr, ram_raddr;
    logic [RAM_W-1:0]              ram_rdata;

    // Register writes; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LEFT:    cfg_next.window_left    = cfg_data[9:0];
                CFG_WINDOW_TOP:     cfg_next.window_top     = cfg_data[8:0];
                CFG_CELL_WIDTH:     cfg_next.cell_width     = cfg_data[8:0];
                CFG_CELL_HEIGHT:    cfg_next.cell_height    = cfg_data[7:0];
                CFG_DARK_THRESHOLD: cfg_next.dark_threshold = cfg_data[7:0];
                CFG_BRIGHT_VALUE:   cfg_next.bright_value   = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // A frame_end pixel is held off until the previous frame's readout is done.
    assign in_ready = !(frame_end && (rd_busy_reg || (ev.valid && ev.last)));
    assign in_xfer  = in_valid && in_ready;

    gdml_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_xfer),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .frame_end (frame_end),
        .cfg       (cfg_reg),
        .ev        (ev)
    );

    // First hit per cell goes into the fill bank; the found flag blocks later hits.
    always_comb
    begin
        found_next   = found_reg;
        wr_bank_next = wr_bank_reg;
        ram_we       = 1'b0;
        ram_waddr    = {wr_bank_reg, ev.cell_id};
        if (ev.valid && ev.hit && !found_reg[wr_bank_reg][ev.cell_id])
        begin
            ram_we                               = 1'b1;
            found_next[wr_bank_reg][ev.cell_id]  = 1'b1;
        end
        if (ev.valid && ev.last)
        begin
            wr_bank_next              = !wr_bank_reg;
            found_next[!wr_bank_reg]  = '0;
        end
    end

    // Readout of the finished bank, one point per transfer slot.
    always_comb
    begin
        rd_busy_next   = rd_busy_reg;
        rd_bank_next   = rd_bank_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;
        advance        = rd_busy_reg && (!out_valid_reg || out_ready);
        ram_re         = advance;
        ram_raddr      = {rd_bank_reg, rd_idx_reg};

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_index_next = rd_idx_reg;
            out_found_next = found_reg[rd_bank_reg][rd_idx_reg];
            out_last_next  = (rd_idx_reg == CELL_W'(CELLS - 1));
            rd_idx_next    = rd_idx_reg + 1'b1;
            if (rd_idx_reg == CELL_W'(CELLS - 1))
            begin
                rd_busy_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (ev.valid && ev.last)
        begin
            rd_busy_next = 1'b1;
            rd_bank_next = wr_bank_reg;
            rd_idx_next  = '0;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_left    <= RST_WINDOW_LEFT;
            cfg_reg.window_top     <= RST_WINDOW_TOP;
            cfg_reg.cell_width     <= RST_CELL_WIDTH;
            cfg_reg.cell_height    <= RST_CELL_HEIGHT;
            cfg_reg.dark_threshold <= RST_DARK_THRESHOLD;
            cfg_reg.bright_value   <= RST_BRIGHT_VALUE;
            wr_bank_reg            <= 1'b0;
            found_reg              <= '0;
            rd_busy_reg            <= 1'b0;
            rd_bank_reg            <= 1'b0;
            rd_idx_reg             <= '0;
            out_valid_reg          <= 1'b0;
            out_index_reg          <= '0;
            out_found_reg          <= 1'b0;
            out_last_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            wr_bank_reg   <= wr_bank_next;
            found_reg     <= found_next;
            rd_busy_reg   <= rd_busy_next;
            rd_bank_reg   <= rd_bank_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_found_reg <= out_found_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Point store: two banks of per-cell coordinates.
    gdml_ram #(
        .WIDTH (RAM_W),
        .DEPTH (RAM_DEPTH)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({ev.x, ev.y}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output fields; cells without a hit report zero coordinates.
    assign out_valid  = out_valid_reg;
    assign cell_index = out_index_reg;
    assign found      = out_found_reg;
    assign last_point = out_last_reg;
    assign point_x    = out_found_reg ? ram_rdata[Y_W +: X_W] : '0;
    assign point_y    = out_found_reg ? ram_rdata[Y_W-1:0] : '0;

    // Checks.
    `GDML_ASSERT_NOW(a_banks_apart, clk, rst_n, rd_busy_reg, rd_bank_reg != wr_bank_reg)
    `GDML_ASSERT_NOW(a_no_end_during_readout, clk, rst_n, in_xfer && frame_end, !rd_busy_reg)
    `GDML_ASSERT_NEXT(a_end_starts_readout, clk, rst_n, ev.valid && ev.last, rd_busy_reg)
    `GDML_ASSERT_NOW(a_miss_is_zero, clk, rst_n, out_valid && !found,
                     (point_x == '0) && (point_y == '0))

endmodule
